// ----- rtl/wov_pkg.sv -----
// Shared types, register indexes and helper functions for the wheel odometry
// velocity block. No dependencies; used by wov_ctrl, wov_dp and the top level.
`timescale 1ns / 1ps
package wov_pkg;

  localparam int unsigned CountWidth   = 16;
  localparam int unsigned TickWidth    = 16;
  localparam int unsigned CfgAddrWidth = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned SpeedWidth   = 32;
  localparam int unsigned PulseWidth   = 16;

  localparam logic [CountWidth-1:0] CountMax = '1;
  localparam logic [TickWidth-1:0]  TickMax  = '1;

  // register indexes on the config port
  localparam logic [CfgAddrWidth-1:0] RegWindowTicks   = 2'd0;
  localparam logic [CfgAddrWidth-1:0] RegSpeedPerPulse = 2'd1;
  localparam logic [CfgAddrWidth-1:0] RegInvWheelbase  = 2'd2;

  localparam logic [TickWidth-1:0]  WindowTicksRst   = 16'd250;
  localparam logic [SpeedWidth-1:0] SpeedPerPulseRst = 32'd0;
  localparam logic [SpeedWidth-1:0] InvWheelbaseRst  = 32'd152409;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_SAT_R,
    ST_MAG,
    ST_MUL_W,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_L,
    OP_MUL_R,
    OP_SAT_R,
    OP_MAG,
    OP_MUL_W,
    OP_LOAD
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic close;
  } sts_t;

  function automatic logic [PulseWidth-1:0] sat_pulses(input logic [CountWidth-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [SpeedWidth-1:0] sat_speed(input logic [63:0] p);
    return (p[63:32] != 32'd0) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

endpackage

// ----- rtl/wov_ctrl.sv -----
// Sequencer for the window math: walks the shared multiplier through the
// speed and turn-rate steps and owns the output word valid flag. Uses wov_pkg.
`timescale 1ns / 1ps
module wov_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              m_ready_i,
  input  wov_pkg::sts_t     sts_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  output wov_pkg::cmd_t     cmd_o
);

  wov_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wov_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.op      = wov_pkg::OP_NONE;
    s_ready_o     = 1'b0;
    case (state_q)
      wov_pkg::ST_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
        if (s_valid_i && sts_i.close) state_d = wov_pkg::ST_MUL_L;
      end
      wov_pkg::ST_MUL_L: begin
        cmd_o.op = wov_pkg::OP_MUL_L;
        state_d  = wov_pkg::ST_MUL_R;
      end
      wov_pkg::ST_MUL_R: begin
        cmd_o.op = wov_pkg::OP_MUL_R;
        state_d  = wov_pkg::ST_SAT_R;
      end
      wov_pkg::ST_SAT_R: begin
        cmd_o.op = wov_pkg::OP_SAT_R;
        state_d  = wov_pkg::ST_MAG;
      end
      wov_pkg::ST_MAG: begin
        cmd_o.op = wov_pkg::OP_MAG;
        state_d  = wov_pkg::ST_MUL_W;
      end
      wov_pkg::ST_MUL_W: begin
        cmd_o.op = wov_pkg::OP_MUL_W;
        state_d  = wov_pkg::ST_FIN;
      end
      wov_pkg::ST_FIN: begin
        // hold here until the output register is free
        if (!out_valid_q || m_ready_i) begin
          cmd_o.op = wov_pkg::OP_LOAD;
          state_d  = wov_pkg::ST_IDLE;
        end
      end
      default: state_d = wov_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == wov_pkg::OP_LOAD) out_valid_d = 1'b1;
    else if (m_ready_i)               out_valid_d = 1'b0;
  end

  assign m_valid_o = out_valid_q;

endmodule

// ----- rtl/wov_dp.sv -----
// Datapath: config registers, edge and tick counters, window snapshot, one
// shared 32x32 multiplier and the result register. Uses wov_pkg.
`timescale 1ns / 1ps
module wov_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [wov_pkg::CfgAddrWidth-1:0]        cfg_addr_i,
  input  logic [wov_pkg::CfgDataWidth-1:0]        cfg_wdata_i,
  input  logic                                   left_edge_i,
  input  logic                                   right_edge_i,
  input  logic                                   ms_tick_i,
  input  wov_pkg::cmd_t                          cmd_i,
  output wov_pkg::sts_t                          sts_o,
  output logic [wov_pkg::PulseWidth-1:0]         left_pulses_o,
  output logic [wov_pkg::PulseWidth-1:0]         right_pulses_o,
  output logic [wov_pkg::SpeedWidth-1:0]         left_speed_o,
  output logic [wov_pkg::SpeedWidth-1:0]         right_speed_o,
  output logic [wov_pkg::SpeedWidth-1:0]         linear_speed_o,
  output logic signed [wov_pkg::SpeedWidth-1:0]  angular_rate_o
);

  localparam int unsigned CW = wov_pkg::CountWidth;
  localparam int unsigned TW = wov_pkg::TickWidth;
  localparam int unsigned SW = wov_pkg::SpeedWidth;

  logic [TW-1:0] window_q;
  logic [SW-1:0] spp_q, iwb_q;

  logic [CW-1:0] left_q, right_q, left_d, right_d, left_bump, right_bump;
  logic [TW-1:0] tick_q, tick_d, tick_bump, win;
  logic          close;

  logic [CW-1:0] lc_q, rc_q;
  logic [SW-1:0] ls_q, rs_q, mag_q, lin_q;
  logic          neg_q;
  logic [SW-1:0] mul_a, mul_b;
  logic [63:0]   prod_q;
  logic [SW:0]   sum;
  logic [47:0]   q48;
  logic [SW-1:0] qc, ang;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= wov_pkg::WindowTicksRst;
      spp_q    <= wov_pkg::SpeedPerPulseRst;
      iwb_q    <= wov_pkg::InvWheelbaseRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        wov_pkg::RegWindowTicks:   window_q <= cfg_wdata_i[TW-1:0];
        wov_pkg::RegSpeedPerPulse: spp_q    <= cfg_wdata_i[SW-1:0];
        wov_pkg::RegInvWheelbase:  iwb_q    <= cfg_wdata_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // edges that come with the closing tick belong to the closing window
  always_comb begin
    left_bump  = (left_edge_i && left_q != wov_pkg::CountMax) ? left_q + CW'(1) : left_q;
    right_bump = (right_edge_i && right_q != wov_pkg::CountMax) ? right_q + CW'(1) : right_q;
    tick_bump  = (ms_tick_i && tick_q != wov_pkg::TickMax) ? tick_q + TW'(1) : tick_q;
    win        = (window_q == '0) ? TW'(1) : window_q;
    close      = ms_tick_i && (tick_bump >= win);
    sts_o.close = close;

    left_d  = left_q;
    right_d = right_q;
    tick_d  = tick_q;
    if (cmd_i.accept) begin
      if (close) begin
        left_d  = '0;
        right_d = '0;
        tick_d  = '0;
      end else begin
        left_d  = left_bump;
        right_d = right_bump;
        tick_d  = tick_bump;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      tick_q  <= '0;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
      tick_q  <= tick_d;
    end
  end

  always_comb begin
    case (cmd_i.op)
      wov_pkg::OP_MUL_L: begin
        mul_a = SW'(lc_q);
        mul_b = spp_q;
      end
      wov_pkg::OP_MUL_R: begin
        mul_a = SW'(rc_q);
        mul_b = spp_q;
      end
      default: begin
        mul_a = mag_q;
        mul_b = iwb_q;
      end
    endcase
    sum = {1'b0, ls_q} + {1'b0, rs_q};
    // turn rate: drop 16 fraction bits, clamp, apply sign
    q48 = prod_q[63:16];
    if (neg_q) begin
      qc  = (q48 > 48'h0000_8000_0000) ? 32'h8000_0000 : q48[31:0];
      ang = 32'd0 - qc;
    end else begin
      qc  = q48[31:0];
      ang = (q48 > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q48[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && close) begin
      lc_q <= left_bump;
      rc_q <= right_bump;
    end
    case (cmd_i.op)
      wov_pkg::OP_MUL_L: prod_q <= mul_a * mul_b;
      wov_pkg::OP_MUL_R: begin
        ls_q   <= wov_pkg::sat_speed(prod_q);
        prod_q <= mul_a * mul_b;
      end
      wov_pkg::OP_SAT_R: rs_q <= wov_pkg::sat_speed(prod_q);
      wov_pkg::OP_MAG: begin
        neg_q <= ls_q > rs_q;
        mag_q <= (ls_q > rs_q) ? ls_q - rs_q : rs_q - ls_q;
        lin_q <= sum[SW:1];
      end
      wov_pkg::OP_MUL_W: prod_q <= mul_a * mul_b;
      wov_pkg::OP_LOAD: begin
        left_pulses_o  <= wov_pkg::sat_pulses(lc_q);
        right_pulses_o <= wov_pkg::sat_pulses(rc_q);
        left_speed_o   <= ls_q;
        right_speed_o  <= rs_q;
        linear_speed_o <= lin_q;
        angular_rate_o <= ang;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/wheel_odometry_velocity.sv -----
// Wheel odometry velocity: edge/tick counting with window speed math.
// A window-closing word walks MUL_L, MUL_R, SAT_R, MAG, MUL_W and FIN, which
// loads the result once the output is free. Throughput: one word per cycle;
// a closing word blocks input through FIN as the shared multiplier runs three products.
// Reset (async, active low) clears counters and valid, loads default config.
`timescale 1ns / 1ps
module wheel_odometry_velocity (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wov_pkg::CfgAddrWidth-1:0]    cfg_addr_i,
  input  logic [wov_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] left_edge, [1] right_edge, [2] ms_tick, [7:3] zero
  input  logic [7:0]                         s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] left_pulses, [31:16] right_pulses, [63:32] left_speed,
  // [95:64] right_speed, [127:96] linear_speed, [159:128] angular_rate
  output logic [159:0]                       m_axis_tdata
);

  wov_pkg::cmd_t cmd;
  wov_pkg::sts_t sts;

  logic [wov_pkg::PulseWidth-1:0]        left_pulses, right_pulses;
  logic [wov_pkg::SpeedWidth-1:0]        left_speed, right_speed, linear_speed;
  logic signed [wov_pkg::SpeedWidth-1:0] angular_rate;

  wov_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  wov_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .left_edge_i    (s_axis_tdata[0]),
    .right_edge_i   (s_axis_tdata[1]),
    .ms_tick_i      (s_axis_tdata[2]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .left_pulses_o  (left_pulses),
    .right_pulses_o (right_pulses),
    .left_speed_o   (left_speed),
    .right_speed_o  (right_speed),
    .linear_speed_o (linear_speed),
    .angular_rate_o (angular_rate)
  );

  assign m_axis_tdata = {angular_rate, linear_speed, right_speed, left_speed,
                         right_pulses, left_pulses};

  // a closing word starts the multiply sequence on the next cycle
  a_close_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && sts.close) |=> (cmd.op == wov_pkg::OP_MUL_L))
    else $error("window close did not start the speed sequence");

  // turn rate sign follows the wheel speed order
  a_turn_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && left_speed > right_speed) |-> (angular_rate <= 0))
    else $error("turn rate sign wrong for left faster than right");

  a_turn_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && right_speed >= left_speed) |-> (angular_rate >= 0))
    else $error("turn rate sign wrong for right faster than left");

  // mean speed lies between the two wheel speeds
  a_linear_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((linear_speed >= left_speed || linear_speed >= right_speed) &&
                       (linear_speed <= left_speed || linear_speed <= right_speed)))
    else $error("linear speed outside wheel speed range");

endmodule
